// File: hdl/som_winner_search_and_update_assert.svh
// Assertion macros for the SOM winner search block.
// No dependencies; included by the top level.
`ifndef SOM_WINNER_SEARCH_AND_UPDATE_ASSERT_SVH
`define SOM_WINNER_SEARCH_AND_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
`define SOM_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SOM_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define SOM_ASSERT_IMP(lbl, clk, rst_n, a, c, msg)
`define SOM_ASSERT_NXT(lbl, clk, rst_n, a, c, msg)
`endif
`endif

// File: hdl/som_pkg.sv
// Package for the SOM winner search block: constants and controller types.
// No dependencies.
package som_pkg;
  localparam int MAP_ROWS     = 8;
  localparam int MAP_COLS     = 8;
  localparam int FEATURE_BITS = 16;
  localparam int DIST_BITS    = 33;
  localparam int RESET_FEATURE = 179;

  localparam logic [1:0] REG_RATE   = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;
  localparam logic [1:0] REG_WFIRST = 2'd2;
  localparam logic [1:0] REG_WSECOND = 2'd3;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_DRAIN = 8'b0000_0100,
    ST_OUT   = 8'b0000_1000,
    ST_TRD   = 8'b0001_0000,
    ST_TWAIT = 8'b0010_0000,
    ST_TMUL  = 8'b0100_0000,
    ST_TWR   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic load;       // capture sample
    logic scan_rd;    // issue scan read
    logic tr_rd;      // issue training read
    logic tr_mul;     // register step products
    logic tr_wr;      // write trained entry
  } cmd_t;

  typedef struct packed {
    logic scan_last;  // last scan address issued
    logic scan_busy;  // distance pipeline still holds reads
    logic tr_valid;   // current cross target in map
    logic tr_last;    // last cross target
  } sts_t;
endpackage

// File: hdl/som_if.sv
// Valid/ready channel interface for the SOM block.
// Depends on nothing; payload type is a parameter.
interface som_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/som_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module som_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: hdl/som_ctrl.sv
// Controller FSM for the SOM block: scan, report, then, for a train item, train the cross.
// Depends on som_pkg.
module som_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          op,
  input  logic          out_ready,
  input  logic          clr_done,
  input  som_pkg::sts_t sts,
  output som_pkg::cmd_t cmd,
  output logic          in_rdy,
  output logic          out_vld
);
  som_pkg::state_t state_r, state_nxt;
  logic train_r, train_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= som_pkg::ST_IDLE;
      train_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      train_r <= train_nxt;
    end
  end

  assign in_rdy  = (state_r == som_pkg::ST_IDLE) && clr_done;
  assign out_vld = (state_r == som_pkg::ST_OUT);

  always_comb begin
    state_nxt = state_r;
    train_nxt = train_r;
    cmd = '0;
    unique case (state_r)
      som_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          train_nxt = op;
          state_nxt = som_pkg::ST_SCAN;
        end
      end
      som_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_nxt = som_pkg::ST_DRAIN;
      end
      som_pkg::ST_DRAIN: begin
        if (!sts.scan_busy) state_nxt = som_pkg::ST_OUT;
      end
      som_pkg::ST_OUT: begin
        if (out_ready) state_nxt = train_r ? som_pkg::ST_TRD : som_pkg::ST_IDLE;
      end
      som_pkg::ST_TRD: begin
        if (sts.tr_valid) begin
          cmd.tr_rd = 1'b1;
          state_nxt = som_pkg::ST_TWAIT;
        end else begin
          cmd.tr_wr = 1'b0;
          state_nxt = sts.tr_last ? som_pkg::ST_IDLE : som_pkg::ST_TRD;
          cmd.tr_mul = 1'b0;
        end
      end
      som_pkg::ST_TWAIT: state_nxt = som_pkg::ST_TMUL;
      som_pkg::ST_TMUL: begin
        cmd.tr_mul = 1'b1;
        state_nxt = som_pkg::ST_TWR;
      end
      som_pkg::ST_TWR: begin
        cmd.tr_wr = 1'b1;
        state_nxt = sts.tr_last ? som_pkg::ST_IDLE : som_pkg::ST_TRD;
      end
      default: state_nxt = som_pkg::ST_IDLE;
    endcase
  end
endmodule

// File: hdl/som_dp.sv
// Datapath for the SOM block: weight RAM, distance pipeline, training step.
// Depends on som_pkg and som_ram.
module som_dp #(
  parameter int MAP_ROWS     = som_pkg::MAP_ROWS,
  parameter int MAP_COLS     = som_pkg::MAP_COLS,
  parameter int FEATURE_BITS = som_pkg::FEATURE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  som_pkg::cmd_t           cmd,
  output som_pkg::sts_t           sts,
  output logic                    clr_done,
  input  logic [FEATURE_BITS-1:0] x0_in,
  input  logic [FEATURE_BITS-1:0] x1_in,
  input  logic [15:0]             rate,
  input  logic [3:0]              radius,
  input  logic [7:0]              wf,
  input  logic [7:0]              ws,
  output logic [2:0]              win_row,
  output logic [2:0]              win_col,
  output logic [som_pkg::DIST_BITS-1:0] win_dist
);
  localparam int N  = MAP_ROWS * MAP_COLS;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int RW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int CW = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
  localparam int FB = FEATURE_BITS;
  localparam int SQ = 2 * FB;
  localparam int TW = SQ + 8;
  localparam int DW = TW - 7;

  logic [FB-1:0] x0_r, x1_r;
  logic [AW:0]   clr_cnt_r;
  logic          clr_busy;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [2*FB-1:0] ram_wdata, ram_rdata;

  som_ram #(.WIDTH(2*FB), .DEPTH(N)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (clr_busy) clr_cnt_r <= clr_cnt_r + 1'b1;
  end
  assign clr_busy = (clr_cnt_r != (AW+1)'(N));
  assign clr_done = !clr_busy;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r <= x0_in;
      x1_r <= x1_in;
    end
  end

  // scan: address counter, read, diff/square, weight, compare
  logic [AW-1:0] scan_addr_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0] a1_r, a2_r, a3_r, a4_r;
  logic [FB-1:0] d0_r, d1_r;
  logic [SQ-1:0] s0_r, s1_r;
  logic [DW-1:0] dist_r;
  logic [DW-1:0] best_r;
  logic [AW-1:0] best_idx_r;
  logic          first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      if (cmd.load) scan_addr_r <= '0;
      else if (cmd.scan_rd) scan_addr_r <= scan_addr_r + 1'b1;
      v1_r <= cmd.scan_rd;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end
  assign sts.scan_last = (scan_addr_r == AW'(N-1));
  assign sts.scan_busy = v1_r || v2_r || v3_r || v4_r;

  logic [FB-1:0] w0, w1;
  assign w0 = ram_rdata[FB-1:0];
  assign w1 = ram_rdata[2*FB-1:FB];

  always_ff @(posedge clk) begin
    a1_r <= scan_addr_r;
    d0_r <= (x0_r >= w0) ? x0_r - w0 : w0 - x0_r;
    d1_r <= (x1_r >= w1) ? x1_r - w1 : w1 - x1_r;
    a2_r <= a1_r;
    s0_r <= SQ'(d0_r) * SQ'(d0_r);
    s1_r <= SQ'(d1_r) * SQ'(d1_r);
    a3_r <= a2_r;
    dist_r <= DW'(((TW+1)'(TW'(s0_r) * TW'(wf)) + (TW+1)'(TW'(s1_r) * TW'(ws))) >> 8);
    a4_r <= a3_r;
    if (cmd.load) first_r <= 1'b1;
    else if (v4_r) begin
      first_r <= 1'b0;
      if (first_r || dist_r < best_r) begin
        best_r <= dist_r;
        best_idx_r <= a4_r;
      end
    end
  end

  logic [RW-1:0] wr_r;
  logic [CW-1:0] wc_r;
  always_comb begin
    wr_r = RW'(best_idx_r / AW'(MAP_COLS));
    wc_r = CW'(best_idx_r % AW'(MAP_COLS));
  end
  assign win_row  = 3'(wr_r);
  assign win_col  = 3'(wc_r);
  assign win_dist = som_pkg::DIST_BITS'(best_r);

  // training: k from 0..radius, dir 0..3 (k=0 only dir 0)
  logic [3:0] k_r;
  logic [1:0] dir_r;
  logic       tr_init_r;
  integer tr, tc;
  always_comb begin
    tr = int'(wr_r);
    tc = int'(wc_r);
    unique case (dir_r)
      2'd0: tr = int'(wr_r) + int'(k_r);
      2'd1: tr = int'(wr_r) - int'(k_r);
      2'd2: tc = int'(wc_r) + int'(k_r);
      2'd3: tc = int'(wc_r) - int'(k_r);
      default: tr = int'(wr_r);
    endcase
  end
  logic tr_step;
  assign tr_step = cmd.tr_wr || (!cmd.tr_rd && !cmd.tr_mul && tr_init_r && !sts.tr_valid);
  assign sts.tr_valid = (tr >= 0) && (tr < MAP_ROWS) && (tc >= 0) && (tc < MAP_COLS);
  assign sts.tr_last  = (k_r >= radius) && ((k_r == 4'd0) || (dir_r == 2'd3));
  logic [AW-1:0] tr_addr;
  assign tr_addr = AW'(tr * MAP_COLS + tc);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      k_r <= '0; dir_r <= '0; tr_init_r <= 1'b1;
    end else if (tr_step) begin
      if (k_r == 4'd0 || dir_r == 2'd3) begin
        k_r <= k_r + 1'b1; dir_r <= 2'd0;
      end else dir_r <= dir_r + 1'b1;
    end
  end

  logic [FB+16-1:0] m0_r, m1_r;
  logic             up0_r, up1_r;
  logic [FB-1:0]    ow0_r, ow1_r;
  always_ff @(posedge clk) begin
    if (cmd.tr_mul) begin
      up0_r <= x0_r >= w0;
      up1_r <= x1_r >= w1;
      ow0_r <= w0;
      ow1_r <= w1;
      m0_r <= (FB+16)'(rate) * (FB+16)'((x0_r >= w0) ? x0_r - w0 : w0 - x0_r);
      m1_r <= (FB+16)'(rate) * (FB+16)'((x1_r >= w1) ? x1_r - w1 : w1 - x1_r);
    end
  end
  logic [FB-1:0] n0, n1;
  assign n0 = up0_r ? ow0_r + m0_r[FB+15:16] : ow0_r - m0_r[FB+15:16];
  assign n1 = up1_r ? ow1_r + m1_r[FB+15:16] : ow1_r - m1_r[FB+15:16];

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = {n1, n0};
    ram_addr = scan_addr_r;
    if (clr_busy) begin
      ram_we = 1'b1;
      ram_addr = clr_cnt_r[AW-1:0];
      ram_wdata = {FB'(som_pkg::RESET_FEATURE), FB'(som_pkg::RESET_FEATURE)};
    end else if (cmd.tr_rd || cmd.tr_mul || cmd.tr_wr || !cmd.scan_rd) begin
      ram_addr = tr_addr;
      ram_we = cmd.tr_wr;
    end
  end
endmodule

// File: hdl/som_winner_search_and_update.sv
// Top level of the SOM winner search and training block.
// Depends on som_pkg, som_if, som_ctrl, som_dp and the assertion header.
// Each item scans all MAP_ROWS*MAP_COLS neurons through one RAM port, one
// neuron a cycle, then drains the distance pipeline and delivers the winner;
// a train item then rewrites the cross around it, passing each neuron in the
// map through the read, wait, multiply and write states and skipping each
// neuron outside it. After reset a clearing pass over all MAP_ROWS*MAP_COLS
// entries loads the map before any item is taken.
`include "som_winner_search_and_update_assert.svh"
module som_winner_search_and_update #(
  parameter int MAP_ROWS     = som_pkg::MAP_ROWS,
  parameter int MAP_COLS     = som_pkg::MAP_COLS,
  parameter int FEATURE_BITS = som_pkg::FEATURE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  som_if.sink         in_ch,
  som_if.source       out_ch,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] rate_r;
  logic [3:0]  radius_r;
  logic [7:0]  wf_r, ws_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= 16'd19661; radius_r <= 4'd4; wf_r <= 8'd77; ws_r <= 8'd179;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        som_pkg::REG_RATE:    rate_r   <= cfg_data;
        som_pkg::REG_RADIUS:  radius_r <= cfg_data[3:0];
        som_pkg::REG_WFIRST:  wf_r     <= cfg_data[7:0];
        som_pkg::REG_WSECOND: ws_r     <= cfg_data[7:0];
        default: rate_r <= rate_r;
      endcase
    end
  end

  som_pkg::cmd_t cmd;
  som_pkg::sts_t sts;
  logic clr_done, in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  som_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .op(in_ch.data.op),
    .out_ready(out_ch.ready), .clr_done(clr_done), .sts(sts), .cmd(cmd),
    .in_rdy(in_ch.ready), .out_vld(out_ch.valid)
  );

  som_dp #(.MAP_ROWS(MAP_ROWS), .MAP_COLS(MAP_COLS), .FEATURE_BITS(FEATURE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .clr_done(clr_done),
    .x0_in(FEATURE_BITS'(in_ch.data.feature_first)),
    .x1_in(FEATURE_BITS'(in_ch.data.feature_second)),
    .rate(rate_r), .radius(radius_r), .wf(wf_r), .ws(ws_r),
    .win_row(out_ch.data.winner_row), .win_col(out_ch.data.winner_col),
    .win_dist(out_ch.data.winner_distance)
  );

  `SOM_ASSERT_IMP(a_no_in_while_out, clk, rst_n, out_ch.valid, !in_ch.ready, "in ready during out")
  `SOM_ASSERT_NXT(a_out_holds, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data.winner_distance), "out dropped")
  `SOM_ASSERT_IMP(a_clear_blocks, clk, rst_n, !clr_done, !in_ch.ready, "input during clear")
endmodule

// File: test/som_winner_search_and_update_checker.sv
// Beat types and scoreboard for the SOM winner search testbench.
// Depends on som_pkg; watches the sample, winner and register channels.
`timescale 1ns / 100ps

package som_tb_pkg;
  typedef struct packed {
    logic        op;
    logic [15:0] feature_first;
    logic [15:0] feature_second;
  } sample_t;

  typedef struct packed {
    logic [2:0]  winner_row;
    logic [2:0]  winner_col;
    logic [32:0] winner_distance;
  } winner_t;
endpackage

module som_winner_search_and_update_checker
  import som_pkg::*;
  import som_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  sample_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  winner_t     out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  localparam int NEURONS = MAP_ROWS * MAP_COLS;

  logic [FEATURE_BITS-1:0] map_w0 [NEURONS];
  logic [FEATURE_BITS-1:0] map_w1 [NEURONS];
  logic [15:0] rate;
  logic [3:0]  radius;
  logic [7:0]  wt_first;
  logic [7:0]  wt_second;
  winner_t     winners_q[$];

  function automatic logic [63:0] abs_diff(logic [15:0] a, logic [15:0] b);
    return (a >= b) ? 64'(a - b) : 64'(b - a);
  endfunction

  function automatic logic [32:0] weighted_dist(int idx, logic [15:0] x0, logic [15:0] x1);
    logic [63:0] d0, d1;
    d0 = abs_diff(x0, map_w0[idx]);
    d1 = abs_diff(x1, map_w1[idx]);
    return 33'((64'(wt_first) * d0 * d0 + 64'(wt_second) * d1 * d1) >> 8);
  endfunction

  function automatic logic [15:0] step_toward(logic [15:0] w, logic [15:0] x);
    logic [63:0] mag;
    if (x >= w) begin
      mag = (64'(rate) * 64'(x - w)) >> 16;
      return w + mag[15:0];
    end
    mag = (64'(rate) * 64'(w - x)) >> 16;
    return w - mag[15:0];
  endfunction

  task automatic pull_neuron(int r, int c, logic [15:0] x0, logic [15:0] x1);
    int idx;
    if (r < 0 || r >= MAP_ROWS || c < 0 || c >= MAP_COLS) return;
    idx = r * MAP_COLS + c;
    map_w0[idx] = step_toward(map_w0[idx], x0);
    map_w1[idx] = step_toward(map_w1[idx], x1);
  endtask

  task automatic predict_winner(sample_t s);
    int best, wr, wc;
    logic [32:0] best_d, d;
    winner_t res;
    best = 0;
    best_d = weighted_dist(0, s.feature_first, s.feature_second);
    for (int i = 1; i < NEURONS; i++) begin
      d = weighted_dist(i, s.feature_first, s.feature_second);
      if (d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    wr = best / MAP_COLS;
    wc = best % MAP_COLS;
    res.winner_row = 3'(wr);
    res.winner_col = 3'(wc);
    res.winner_distance = best_d;
    winners_q.push_back(res);
    if (s.op) begin
      pull_neuron(wr, wc, s.feature_first, s.feature_second);
      for (int k = 1; k <= int'(radius); k++) begin
        pull_neuron(wr + k, wc, s.feature_first, s.feature_second);
        pull_neuron(wr - k, wc, s.feature_first, s.feature_second);
        pull_neuron(wr, wc + k, s.feature_first, s.feature_second);
        pull_neuron(wr, wc - k, s.feature_first, s.feature_second);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    winner_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < NEURONS; i++) begin
        map_w0[i] = 16'(RESET_FEATURE);
        map_w1[i] = 16'(RESET_FEATURE);
      end
      rate = 16'd19661;
      radius = 4'd4;
      wt_first = 8'd77;
      wt_second = 8'd179;
      winners_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (winners_q.size() == 0) begin
          $error("winner beat with nothing expected");
          fail_count++;
        end else begin
          exp_w = winners_q.pop_front();
          if (out_data.winner_row !== exp_w.winner_row) begin
            $error("winner_row expected %0d got %0d", exp_w.winner_row, out_data.winner_row);
            fail_count++;
          end
          if (out_data.winner_col !== exp_w.winner_col) begin
            $error("winner_col expected %0d got %0d", exp_w.winner_col, out_data.winner_col);
            fail_count++;
          end
          if (out_data.winner_distance !== exp_w.winner_distance) begin
            $error("winner_distance expected %0d got %0d", exp_w.winner_distance,
                   out_data.winner_distance);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RATE:    rate = cfg_data;
          REG_RADIUS:  radius = cfg_data[3:0];
          REG_WFIRST:  wt_first = cfg_data[7:0];
          REG_WSECOND: wt_second = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_winner(in_data);
    end
    pending = winners_q.size();
  end
endmodule

// File: test/som_winner_search_and_update_tb.sv
// Testbench top for the SOM winner search and training block.
// Depends on som_pkg, som_if, the block and the checker; drives beats, gives verdict.
`timescale 1ns / 100ps

module som_winner_search_and_update_tb;
  import som_pkg::*;
  import som_tb_pkg::*;

  localparam int LIMIT = 4000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  bit          idle_on;
  int          long_hold;
  int          cycles;
  logic [15:0] centers[4];

  som_if #(.payload_t(sample_t)) in_ch ();
  som_if #(.payload_t(winner_t)) out_ch ();

  som_winner_search_and_update i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  som_winner_search_and_update_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side: random stall bursts while idle_on, plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        stall_left = long_hold;
        long_hold = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
      end
    end
  end

  task automatic send_sample(logic op, logic [15:0] f0, logic [15:0] f1);
    int gap;
    sample_t s;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s.op = op;
    s.feature_first = f0;
    s.feature_second = f1;
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] r, logic [15:0] rad, logic [15:0] wf, logic [15:0] ws);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    write_reg(REG_RATE, r);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_WFIRST, wf);
    write_reg(REG_WSECOND, ws);
  endtask

  function automatic logic [15:0] pick_feature();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return centers[$urandom_range(0, 3)] + 16'($urandom_range(0, 1023)) - 16'd512;
  endfunction

  task automatic random_phase(int n);
    logic [15:0] f0;
    for (int i = 0; i < 4; i++) centers[i] = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      f0 = pick_feature();
      send_sample(1'($urandom_range(0, 2) != 0), f0, pick_feature());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    idle_on = 1'b1;
    long_hold = 0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset map: every neuron ties, first one wins, until train items move it
    send_sample(1'b0, 16'd179, 16'd179);
    send_sample(1'b0, 16'h0000, 16'h0000);
    send_sample(1'b0, 16'hFFFF, 16'hFFFF);
    send_sample(1'b1, 16'hFFFF, 16'h0000);
    send_sample(1'b1, 16'h0000, 16'hFFFF);
    send_sample(1'b0, 16'hFFFF, 16'h0000);
    send_sample(1'b1, 16'h1234, 16'h8000);
    // full rate, radius beyond the map, full weights
    set_regs(16'hFFFF, 16'd15, 16'd255, 16'd255);
    send_sample(1'b1, 16'hFFFF, 16'hFFFF);
    send_sample(1'b0, 16'hFFFF, 16'hFFFF);
    send_sample(1'b1, 16'h0000, 16'h0000);
    send_sample(1'b0, 16'h00FF, 16'hFF00);
    // radius zero, zero weights: all distances zero
    set_regs(16'h8000, 16'd0, 16'd0, 16'd0);
    send_sample(1'b1, 16'hAAAA, 16'h5555);
    send_sample(1'b0, 16'h5555, 16'hAAAA);
    // zero rate leaves the map alone
    set_regs(16'd0, 16'd8, 16'd1, 16'd255);
    send_sample(1'b1, 16'h7FFF, 16'h8001);
    send_sample(1'b0, 16'h7FFF, 16'h8001);

    set_regs(16'd19661, 16'd4, 16'd77, 16'd179);
    random_phase(250);
    set_regs(16'($urandom), 16'($urandom_range(0, 15)), 16'($urandom_range(0, 255)),
             16'($urandom_range(0, 255)));
    long_hold = 3000;
    random_phase(250);
    set_regs(16'hFFFF, 16'd8, 16'd255, 16'd1);
    random_phase(250);
    set_regs(16'd1, 16'd1, 16'd128, 16'd128);
    random_phase(250);
    set_regs(16'($urandom), 16'($urandom_range(0, 15)), 16'($urandom_range(0, 255)),
             16'($urandom_range(0, 255)));
    random_phase(250);
    set_regs(16'd40000, 16'd2, 16'd200, 16'd60);
    idle_on = 1'b0;
    random_phase(250);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
